### sv/stfp_pkg.sv
// Types and constants shared by the SMS TPDU field parser.
package stfp_pkg;

   typedef enum logic [3:0] {
      PH_HDR   = 4'd0,
      PH_MR    = 4'd1,
      PH_ALEN  = 4'd2,
      PH_ATYPE = 4'd3,
      PH_ADDR  = 4'd4,
      PH_PID   = 4'd5,
      PH_DCS   = 4'd6,
      PH_VP    = 4'd7,
      PH_SCTS  = 4'd8,
      PH_DT    = 4'd9,
      PH_ST    = 4'd10,
      PH_UDL   = 4'd11,
      PH_UDHL  = 4'd12,
      PH_UDH   = 4'd13,
      PH_PAY   = 4'd14,
      PH_TRAIL = 4'd15
   } phase_type;

   typedef enum logic [1:0] {
      KIND_DELIVER  = 2'd0,
      KIND_SUBMIT   = 2'd1,
      KIND_STATUS   = 2'd2,
      KIND_RESERVED = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_SHORT = 2'd1,
      ST_TRUNC = 2'd2
   } status_type;

   localparam logic [1:0] VPF_NONE     = 2'd0;
   localparam logic [1:0] VPF_RELATIVE = 2'd2;
   localparam int         UDHI_BIT     = 6;
   localparam logic [7:0] VP_LONG_LEN  = 8'd7;
   localparam logic [7:0] TS_LEN       = 8'd7;
   localparam logic [7:0] ONE_LEN      = 8'd1;
   localparam logic [7:0] OFFSET_MAX   = 8'hFF;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       pdu_last;
   } req_payload_type;

   typedef struct packed {
      logic [3:0] field_code;
      logic [7:0] byte_value;
      logic [7:0] field_offset;
      logic [1:0] pdu_kind;
      logic [1:0] parse_status;
      logic       pdu_end;
   } rsp_payload_type;

endpackage

### sv/sms_tpdu_field_parser.sv
// SMS TPDU field parser: tags each octet with its field, offset, PDU kind and status.
//
// Usage: feed the TPDU one octet per transaction on the req_ channel, with
// pdu_last set on the final octet; the next octet after it starts a new PDU.
// Every accepted octet yields exactly one transaction on the rsp_ channel,
// carrying the field code, the octet, its offset within the field
// (saturating at 255), the PDU kind from the header's two low bits, and on
// the last octet the parse status (ok, too short, truncated).
// Each result is registered: it enters the result register, or the skid entry
// while that register is held. Throughput is one octet per cycle while req_ready
// is high, set by the tagging state registers updated on every accepted octet.
// The result register is backed by a one-entry skid buffer, so one more
// octet is accepted while a result waits; req_ready drops only while the
// skid entry is occupied, and both entries hold their contents until taken.
// Reset empties both entries and returns the parser to expect a header octet.
module sms_tpdu_field_parser
   import stfp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   phase_type       phase_ff, phase_in, fd_phase;
   logic [7:0]      bytes_left_ff, bytes_left_in, fd_len;
   logic [7:0]      offset_ff, offset_in, offset_inc, bl_dec;
   logic [7:0]      header_ff, header_in;
   logic [8:0]      alen_sum;
   kind_type        kind;
   status_type      status;
   logic            push, pop;
   logic            main_vld_ff, skid_vld_ff;
   rsp_payload_type main_ff, skid_ff, result;

   assign push      = req_valid && req_ready;
   assign pop       = main_vld_ff && rsp_ready;
   assign req_ready = !skid_vld_ff;
   assign rsp_valid = main_vld_ff;
   assign rsp_payload = main_ff;

   always_comb begin
      header_in  = (phase_ff == PH_HDR) ? req_payload.byte_in : header_ff;
      kind       = kind_type'(header_in[1:0]);
      alen_sum   = {1'b0, req_payload.byte_in} + 9'd1;
      offset_inc = (offset_ff != OFFSET_MAX) ? offset_ff + 8'd1 : offset_ff;
      bl_dec     = (bytes_left_ff != 8'd0) ? bytes_left_ff - 8'd1 : 8'd0;

      fd_phase = phase_ff;
      fd_len   = bytes_left_ff;
      case (phase_ff)
         PH_HDR: begin
            if (kind == KIND_DELIVER) begin
               fd_phase = PH_ALEN; fd_len = ONE_LEN;
            end else if (kind == KIND_RESERVED) begin
               fd_phase = PH_PAY; fd_len = 8'd0;
            end else begin
               fd_phase = PH_MR; fd_len = ONE_LEN;
            end
         end
         PH_MR: begin
            fd_phase = PH_ALEN; fd_len = ONE_LEN;
         end
         PH_ALEN: begin
            fd_phase = PH_ATYPE; fd_len = alen_sum[8:1];
         end
         PH_ATYPE, PH_ADDR: begin
            if (phase_ff == PH_ATYPE && bytes_left_ff != 8'd0) begin
               fd_phase = PH_ADDR; fd_len = bytes_left_ff;
            end else if (kind == KIND_STATUS) begin
               fd_phase = PH_SCTS; fd_len = TS_LEN;
            end else begin
               fd_phase = PH_PID; fd_len = ONE_LEN;
            end
         end
         PH_PID: begin
            fd_phase = PH_DCS; fd_len = ONE_LEN;
         end
         PH_DCS: begin
            if (kind == KIND_SUBMIT) begin
               if (header_in[4:3] == VPF_RELATIVE) begin
                  fd_phase = PH_VP; fd_len = ONE_LEN;
               end else if (header_in[4:3] != VPF_NONE) begin
                  fd_phase = PH_VP; fd_len = VP_LONG_LEN;
               end else begin
                  fd_phase = PH_UDL; fd_len = ONE_LEN;
               end
            end else begin
               fd_phase = PH_SCTS; fd_len = TS_LEN;
            end
         end
         PH_VP: begin
            fd_phase = PH_UDL; fd_len = ONE_LEN;
         end
         PH_SCTS: begin
            if (kind == KIND_STATUS) begin
               fd_phase = PH_DT; fd_len = TS_LEN;
            end else begin
               fd_phase = PH_UDL; fd_len = ONE_LEN;
            end
         end
         PH_DT: begin
            fd_phase = PH_ST; fd_len = ONE_LEN;
         end
         PH_ST: begin
            fd_phase = PH_TRAIL; fd_len = 8'd0;
         end
         PH_UDL: begin
            if (header_in[UDHI_BIT]) begin
               fd_phase = PH_UDHL; fd_len = ONE_LEN;
            end else begin
               fd_phase = PH_PAY; fd_len = 8'd0;
            end
         end
         PH_UDHL: begin
            if (req_payload.byte_in != 8'd0) begin
               fd_phase = PH_UDH; fd_len = req_payload.byte_in;
            end else begin
               fd_phase = PH_PAY; fd_len = 8'd0;
            end
         end
         PH_UDH: begin
            fd_phase = PH_PAY; fd_len = 8'd0;
         end
         default: begin
            fd_phase = phase_ff;
            fd_len   = bytes_left_ff;
         end
      endcase

      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      offset_in     = offset_ff;
      if (phase_ff == PH_PAY || phase_ff == PH_TRAIL) begin
         offset_in = offset_inc;
      end else if (phase_ff == PH_HDR || phase_ff == PH_ALEN ||
                   phase_ff == PH_ATYPE || phase_ff == PH_UDHL) begin
         phase_in      = fd_phase;
         bytes_left_in = fd_len;
         offset_in     = 8'd0;
      end else if (bl_dec == 8'd0) begin
         phase_in      = fd_phase;
         bytes_left_in = fd_len;
         offset_in     = 8'd0;
      end else begin
         bytes_left_in = bl_dec;
         offset_in     = offset_inc;
      end

      status = ST_OK;
      if (req_payload.pdu_last) begin
         if (phase_ff == PH_HDR) begin
            status = ST_SHORT;
         end else if (phase_in != PH_PAY && phase_in != PH_TRAIL) begin
            status = ST_TRUNC;
         end
         phase_in      = PH_HDR;
         bytes_left_in = 8'd0;
         offset_in     = 8'd0;
      end

      result.field_code   = phase_ff;
      result.byte_value   = req_payload.byte_in;
      result.field_offset = offset_ff;
      result.pdu_kind     = kind;
      result.parse_status = status;
      result.pdu_end      = req_payload.pdu_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HDR;
         bytes_left_ff <= 8'd0;
         offset_ff     <= 8'd0;
         header_ff     <= 8'd0;
      end else if (push) begin
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
         offset_ff     <= offset_in;
         header_ff     <= header_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (!main_vld_ff || pop) begin
         if (skid_vld_ff) begin
            main_vld_ff <= 1'b1;
            skid_vld_ff <= 1'b0;
         end else begin
            main_vld_ff <= push;
         end
      end else if (push) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!main_vld_ff || pop) begin
         main_ff <= skid_vld_ff ? skid_ff : result;
      end else if (push) begin
         skid_ff <= result;
      end
   end

   a_skid_needs_main: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> main_vld_ff)
      else $error("skid entry held while result register empty");

   a_status_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.pdu_end |-> rsp_payload.parse_status == ST_OK)
      else $error("parse status reported before last octet");

   a_header_after_last: assert property (@(posedge clock) disable iff (reset)
      push && req_payload.pdu_last |=> phase_ff == PH_HDR)
      else $error("parser not back at header after last octet");

   a_header_offset_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.field_code == PH_HDR |-> rsp_payload.field_offset == 8'd0)
      else $error("header octet tagged with nonzero offset");

endmodule

### verif/tpdu_tag_checker.sv
// Scoreboard for the SMS TPDU field parser: predicts each octet's tag and checks every result.
module tpdu_tag_checker
   import stfp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_ready,
   input  req_payload_type req_payload,
   input  logic            rsp_valid,
   input  logic            rsp_ready,
   input  rsp_payload_type rsp_payload,
   output int              mismatch_count,
   output int              tags_pending,
   output int              tags_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PRINT_CAP = 40;

   phase_type       cur_phase;
   logic [7:0]      octets_left;
   logic [7:0]      field_pos;
   logic [7:0]      hdr_octet;
   rsp_payload_type expected_tags[$];
   rsp_payload_type want;

   function automatic void enter_field(input phase_type p, input logic [7:0] len);
      cur_phase   = p;
      octets_left = len;
      field_pos   = 8'd0;
   endfunction

   function automatic void follow_address();
      if (kind_type'(hdr_octet[1:0]) == KIND_STATUS) enter_field(PH_SCTS, TS_LEN);
      else enter_field(PH_PID, ONE_LEN);
   endfunction

   function automatic void bump_pos();
      if (field_pos != OFFSET_MAX) field_pos = field_pos + 8'd1;
   endfunction

   function automatic void close_field(input phase_type p, input logic [7:0] octet);
      kind_type   kind;
      logic [1:0] vpf;
      logic [8:0] addr_octets;
      kind        = kind_type'(hdr_octet[1:0]);
      vpf         = hdr_octet[4:3];
      addr_octets = ({1'b0, octet} + 9'd1) >> 1;
      case (p)
         PH_HDR: begin
            if (kind == KIND_DELIVER) enter_field(PH_ALEN, ONE_LEN);
            else if (kind == KIND_RESERVED) enter_field(PH_PAY, 8'd0);
            else enter_field(PH_MR, ONE_LEN);
         end
         PH_MR: enter_field(PH_ALEN, ONE_LEN);
         PH_ALEN: enter_field(PH_ATYPE, addr_octets[7:0]);
         PH_ATYPE: begin
            if (octets_left != 8'd0) enter_field(PH_ADDR, octets_left);
            else follow_address();
         end
         PH_ADDR: follow_address();
         PH_PID: enter_field(PH_DCS, ONE_LEN);
         PH_DCS: begin
            if (kind == KIND_SUBMIT) begin
               if (vpf == VPF_RELATIVE) enter_field(PH_VP, ONE_LEN);
               else if (vpf != VPF_NONE) enter_field(PH_VP, VP_LONG_LEN);
               else enter_field(PH_UDL, ONE_LEN);
            end else begin
               enter_field(PH_SCTS, TS_LEN);
            end
         end
         PH_VP: enter_field(PH_UDL, ONE_LEN);
         PH_SCTS: begin
            if (kind == KIND_STATUS) enter_field(PH_DT, TS_LEN);
            else enter_field(PH_UDL, ONE_LEN);
         end
         PH_DT: enter_field(PH_ST, ONE_LEN);
         PH_ST: enter_field(PH_TRAIL, 8'd0);
         PH_UDL: begin
            if (hdr_octet[UDHI_BIT]) enter_field(PH_UDHL, ONE_LEN);
            else enter_field(PH_PAY, 8'd0);
         end
         PH_UDHL: begin
            if (octet != 8'd0) enter_field(PH_UDH, octet);
            else enter_field(PH_PAY, 8'd0);
         end
         PH_UDH: enter_field(PH_PAY, 8'd0);
         default: ;
      endcase
   endfunction

   function automatic rsp_payload_type tag_octet(input logic [7:0] octet, input logic last);
      rsp_payload_type tag;
      phase_type       p;
      p                = cur_phase;
      tag.field_code   = p;
      tag.byte_value   = octet;
      tag.field_offset = field_pos;
      tag.parse_status = ST_OK;
      tag.pdu_end      = last;
      if (p == PH_HDR) hdr_octet = octet;
      if (p == PH_PAY || p == PH_TRAIL) begin
         bump_pos();
      end else if (p == PH_HDR || p == PH_ALEN || p == PH_ATYPE || p == PH_UDHL) begin
         close_field(p, octet);
      end else begin
         bump_pos();
         if (octets_left != 8'd0) octets_left = octets_left - 8'd1;
         if (octets_left == 8'd0) close_field(p, octet);
      end
      if (last) begin
         if (p == PH_HDR) tag.parse_status = ST_SHORT;
         else if (cur_phase != PH_PAY && cur_phase != PH_TRAIL) tag.parse_status = ST_TRUNC;
         enter_field(PH_HDR, 8'd0);
      end
      tag.pdu_kind = hdr_octet[1:0];
      return tag;
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] expected_value);
      if (mismatch_count < PRINT_CAP)
         $display("[%0t] tag mismatch on %s: got %h, expected %h", $time, what, got,
                  expected_value);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         enter_field(PH_HDR, 8'd0);
         hdr_octet = 8'd0;
         expected_tags.delete();
         mismatch_count = 0;
         tags_checked   = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_tags.size() == 0) begin
               report_mismatch("unexpected result", rsp_payload.byte_value, 8'h00);
            end else begin
               want = expected_tags.pop_front();
               tags_checked++;
               if (rsp_payload.field_code !== want.field_code)
                  report_mismatch("field_code", 8'(rsp_payload.field_code),
                                  8'(want.field_code));
               if (rsp_payload.byte_value !== want.byte_value)
                  report_mismatch("byte_value", rsp_payload.byte_value, want.byte_value);
               if (rsp_payload.field_offset !== want.field_offset)
                  report_mismatch("field_offset", rsp_payload.field_offset,
                                  want.field_offset);
               if (rsp_payload.pdu_kind !== want.pdu_kind)
                  report_mismatch("pdu_kind", 8'(rsp_payload.pdu_kind),
                                  8'(want.pdu_kind));
               if (rsp_payload.parse_status !== want.parse_status)
                  report_mismatch("parse_status", 8'(rsp_payload.parse_status),
                                  8'(want.parse_status));
               if (rsp_payload.pdu_end !== want.pdu_end)
                  report_mismatch("pdu_end", 8'(rsp_payload.pdu_end), 8'(want.pdu_end));
            end
         end
         if (req_valid && req_ready)
            expected_tags.push_back(tag_octet(req_payload.byte_in, req_payload.pdu_last));
      end
      tags_pending = expected_tags.size();
   end

endmodule

### verif/tb_top.sv
// Top-level testbench for the SMS TPDU field parser: clock, reset, octet traffic and verdict.
module tb_top
   import stfp_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_TARGET = 1300;
   localparam int HOLD_CYCLES = 64;
   localparam int DRAIN       = 10;
   localparam int CYCLE_LIMIT = 400000;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;

   int              mismatch_count;
   int              tags_pending;
   int              tags_checked;

   req_payload_type octet_stream[$];
   logic [7:0]      pdu_octets[$];
   int              pdu_count = 0;
   int              octets_sent = 0;
   int              hold_point = 0;
   bit              hold_done = 1'b0;
   int              tx_idle_pct = 20;
   int              rx_idle_pct = 72;
   int              cycle_count = 0;

   always #2 clock = ~clock;

   sms_tpdu_field_parser dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   tpdu_tag_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_payload    (rsp_payload),
      .mismatch_count (mismatch_count),
      .tags_pending   (tags_pending),
      .tags_checked   (tags_checked)
   );

   task automatic push_random(input int n);
      for (int k = 0; k < n; k++) pdu_octets.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic commit_pdu(input int keep);
      req_payload_type item;
      for (int k = 0; k < keep; k++) begin
         item.byte_in  = pdu_octets[k];
         item.pdu_last = (k == keep - 1);
         octet_stream.push_back(item);
      end
      pdu_octets.delete();
      pdu_count++;
   endtask

   task automatic build_random_pdu(input int tail_count);
      logic [7:0] hdr;
      logic [7:0] alen;
      logic [7:0] udhl;
      kind_type   kind;
      hdr  = 8'($urandom_range(0, 255));
      kind = kind_type'(hdr[1:0]);
      pdu_octets.push_back(hdr);
      if (kind == KIND_RESERVED) begin
         push_random(tail_count);
      end else begin
         if (kind != KIND_DELIVER) push_random(1);
         alen = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, 20));
         pdu_octets.push_back(alen);
         push_random(1);
         push_random((int'(alen) + 1) / 2);
         if (kind == KIND_STATUS) begin
            push_random(int'(TS_LEN) * 2 + 1);
         end else begin
            push_random(2);
            if (kind == KIND_SUBMIT) begin
               if (hdr[4:3] == VPF_RELATIVE) push_random(1);
               else if (hdr[4:3] != VPF_NONE) push_random(int'(VP_LONG_LEN));
            end else begin
               push_random(int'(TS_LEN));
            end
            push_random(1);
            if (hdr[UDHI_BIT]) begin
               udhl = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(0, 8));
               pdu_octets.push_back(udhl);
               push_random(int'(udhl));
            end
         end
         push_random(tail_count);
      end
   endtask

   task automatic build_stimulus();
      int roll;
      pdu_octets = '{8'hFF};
      commit_pdu(1);
      pdu_octets = '{8'h00, 8'hFF};
      commit_pdu(2);
      pdu_octets = '{8'h51, 8'h00, 8'h00, 8'h91, 8'hFF, 8'h00, 8'hAA, 8'h00, 8'h00};
      commit_pdu(9);
      pdu_octets = '{8'h03, 8'h7F, 8'h80};
      commit_pdu(3);
      pdu_octets = '{8'h00};
      commit_pdu(1);
      build_random_pdu(300);
      commit_pdu(pdu_octets.size());
      while (octet_stream.size() < ITEM_TARGET) begin
         roll = $urandom_range(0, 99);
         if (roll < 6) begin
            push_random($urandom_range(1, 6));
            commit_pdu(pdu_octets.size());
         end else begin
            build_random_pdu($urandom_range(0, 12));
            if (roll < 20) commit_pdu($urandom_range(1, pdu_octets.size()));
            else commit_pdu(pdu_octets.size());
         end
      end
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
                  tags_pending);
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin : receiver
      forever begin
         @(posedge clock);
         if (!reset && !hold_done && hold_point > 0 && octets_sent >= hold_point) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   initial begin : stimulus
      int total;
      build_stimulus();
      total      = octet_stream.size();
      hold_point = (2 * total) / 3 + 10;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < total; i++) begin
         if (i < total / 3) begin
            tx_idle_pct = 20;
            rx_idle_pct = 72;
         end else if (i < (2 * total) / 3) begin
            tx_idle_pct = 72;
            rx_idle_pct = 20;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         octets_sent = i;
         if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
         req_valid   <= 1'b1;
         req_payload <= octet_stream[i];
         @(posedge clock);
         while (!req_ready) @(posedge clock);
      end
      octets_sent = total;
      req_valid <= 1'b0;
      @(posedge clock);
      wait (tags_pending == 0);
      repeat (DRAIN) @(posedge clock);
      $display("Checked %0d tagged octets from %0d PDUs, including short, truncated,",
               tags_checked, pdu_count);
      $display("long-payload and malformed PDUs under three flow-control mixes and a hold.");
      if (mismatch_count == 0 && tags_pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### filelist.f
sv/stfp_pkg.sv
sv/sms_tpdu_field_parser.sv
verif/tpdu_tag_checker.sv
verif/tb_top.sv
